// ----- hw/rtl/hsvrgb_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsvrgb_pkg;

	// Fixed field widths
	localparam int HUE_W  = 15;
	localparam int Q8_W   = 9;
	localparam int ONE_Q8 = 256;

	// Fixed-point scaling of hue and of the output components
	localparam int HUE_FRAC_BITS  = 6;
	localparam int COMPONENT_BITS = 8;
	localparam int COMP_MAX       = (1 << COMPONENT_BITS) - 1;

	// Hue circle and one 60 degree sector in hue units
	localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
	localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
	localparam int SECTOR_NUM = 6;
	localparam int SECTOR_W   = 3;

	// Sector remainder and its complement (complement may reach HUE_SECTOR)
	localparam int REM_W  = $clog2(HUE_SECTOR);
	localparam int DIFF_W = $clog2(HUE_SECTOR + 1);
	localparam int PROD_W = Q8_W + DIFF_W;

	// HUE_SECTOR = 15 << (HUE_FRAC_BITS + 2): divide by the power of two with a
	// shift, then by 15 with a rounded-up reciprocal. The shifted product is never
	// above 256 * 15, where the reciprocal gives the exact quotient.
	localparam int SECTOR_SHIFT = HUE_FRAC_BITS + 2;
	localparam int Y_W          = PROD_W - SECTOR_SHIFT;
	localparam int RECIP_SHIFT  = 16;
	localparam int RECIP_15     = ((1 << RECIP_SHIFT) + 14) / 15;
	localparam int RECIP_W      = $clog2(RECIP_15 + 1);

	// Words between the front and the back
	localparam int QUEUE_DEPTH = 4;

	// Sector codes
	typedef enum logic [SECTOR_W-1:0] {
		SEC_RED_YELLOW   = 3'd0,
		SEC_YELLOW_GREEN = 3'd1,
		SEC_GREEN_CYAN   = 3'd2,
		SEC_CYAN_BLUE    = 3'd3,
		SEC_BLUE_MAGENTA = 3'd4,
		SEC_MAGENTA_RED  = 3'd5
	} sector_t;

	// Classified pixel word held in the queue
	typedef struct packed {
		logic              gray;
		sector_t           sector;
		logic [REM_W-1:0]  rem;
		logic [Q8_W-1:0]   sat;
		logic [Q8_W-1:0]   val;
	} hsv_item_t;

	// Queue fill status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsvrgb_front.sv -----
// Front end: accepts HSV words, reduces hue, clamps saturation and value,
// and classifies each word into sector and remainder. Uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              pixel_valid,
	output logic                             pixel_stall,
	input  wire  [hsvrgb_pkg::HUE_W-1:0]     hue,
	input  wire  [hsvrgb_pkg::Q8_W-1:0]      saturation,
	input  wire  [hsvrgb_pkg::Q8_W-1:0]      brightness,
	input  hsvrgb_pkg::queue_status_t        status,
	output logic                             push,
	output hsvrgb_pkg::hsv_item_t            push_item
);
	import hsvrgb_pkg::*;

	logic              valid_s1;
	logic [HUE_W-1:0]  hue_s1;
	logic [Q8_W-1:0]   sat_s1;
	logic [Q8_W-1:0]   val_s1;
	logic              advance;
	logic [HUE_W-1:0]  hue_red;
	logic [Q8_W-1:0]   sat_clamp;
	logic [Q8_W-1:0]   val_clamp;
	sector_t           sector;
	logic [HUE_W-1:0]  base;
	logic [HUE_W-1:0]  rem_full;

	// Hold the stage while the queue is full
	assign advance     = !valid_s1 || !status.full;
	assign pixel_stall = !advance;
	assign push        = valid_s1 && !status.full;

	// Reduce hue into one turn
	always_comb begin
		if (hue >= HUE_W'(HUE_FULL)) begin
			hue_red = hue - HUE_W'(HUE_FULL);
		end else begin
			hue_red = hue;
		end
	end

	// Clamp the Q1.8 inputs to 1.0
	hsvrgb_clamp u_sat_clamp (
		.din  (saturation),
		.dout (sat_clamp)
	);

	hsvrgb_clamp u_val_clamp (
		.din  (brightness),
		.dout (val_clamp)
	);

	// Valid bit of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pixel_valid;
		end
	end

	// Payload of the input stage
	always_ff @(posedge clk) begin
		if (advance && pixel_valid) begin
			hue_s1 <= hue_red;
			sat_s1 <= sat_clamp;
			val_s1 <= val_clamp;
		end
	end

	// Find the sector by comparing against each sector boundary
	always_comb begin
		sector = SEC_RED_YELLOW;
		base   = '0;
		for (int k = 1; k < SECTOR_NUM; k++) begin
			if (hue_s1 >= HUE_W'(k * HUE_SECTOR)) begin
				sector = sector_t'(k[SECTOR_W-1:0]);
				base   = HUE_W'(k * HUE_SECTOR);
			end
		end
		rem_full = hue_s1 - base;
	end

	// Build the queue word
	always_comb begin
		push_item.gray   = (sat_s1 == '0);
		push_item.sector = sector;
		push_item.rem    = rem_full[REM_W-1:0];
		push_item.sat    = sat_s1;
		push_item.val    = val_s1;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_queue.sv -----
// Short queue of classified words between front and back.
// Flip-flop storage, one push and one pop port. Uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_queue #(
	parameter int DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  hsvrgb_pkg::hsv_item_t      push_item,
	input  wire                        pop,
	output hsvrgb_pkg::hsv_item_t      pop_item,
	output hsvrgb_pkg::queue_status_t  status
);
	import hsvrgb_pkg::*;

	// DEPTH must be at least 2
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hsv_item_t         entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_item     = entries_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_back.sv -----
// Back end: forms p, q and t, selects the channels by sector and scales
// them to output width. Four-stage pipeline. Uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  hsvrgb_pkg::queue_status_t            status,
	input  hsvrgb_pkg::hsv_item_t                pop_item,
	output logic                                 pop,
	output logic                                 color_valid,
	input  wire                                  color_stall,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0] red,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0] green,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0] blue
);
	import hsvrgb_pkg::*;

	localparam int SCALE_W = Q8_W + COMPONENT_BITS;
	localparam int YR_W    = Y_W + RECIP_W;

	function automatic logic [COMPONENT_BITS-1:0] scale_out(input logic [Q8_W-1:0] c);
		logic [SCALE_W-1:0] prod;
		prod = SCALE_W'(c) * SCALE_W'(COMP_MAX);
		return prod[8 +: COMPONENT_BITS];
	endfunction

	logic                   advance;
	logic                   out_valid_q;

	// Stage 1 registers
	logic                   valid_s1;
	logic                   gray_s1;
	sector_t                sector_s1;
	logic [PROD_W-1:0]      sf_prod_s1;
	logic [PROD_W-1:0]      sfc_prod_s1;
	logic [Q8_W-1:0]        p_s1;
	logic [Q8_W-1:0]        val_s1;

	// Stage 2 registers (s * (1 - f) may reach 1.0 when the remainder is zero)
	logic                   valid_s2;
	logic                   gray_s2;
	sector_t                sector_s2;
	logic [Q8_W-1:0]        sf_s2;
	logic [Q8_W-1:0]        sfc_s2;
	logic [Q8_W-1:0]        p_s2;
	logic [Q8_W-1:0]        val_s2;

	// Stage 3 registers
	logic                   valid_s3;
	logic                   gray_s3;
	sector_t                sector_s3;
	logic [Q8_W-1:0]        p_s3;
	logic [Q8_W-1:0]        q_s3;
	logic [Q8_W-1:0]        t_s3;
	logic [Q8_W-1:0]        val_s3;

	// Combinational values
	logic [DIFF_W-1:0]      rem_c;
	logic [2*Q8_W-1:0]      p_prod;
	logic [Y_W-1:0]         y_sf;
	logic [Y_W-1:0]         y_sfc;
	logic [YR_W-1:0]        sf_full;
	logic [YR_W-1:0]        sfc_full;
	logic [2*Q8_W-1:0]      q_prod;
	logic [2*Q8_W-1:0]      t_prod;
	logic [Q8_W-1:0]        r_sel;
	logic [Q8_W-1:0]        g_sel;
	logic [Q8_W-1:0]        b_sel;

	// Advance the whole pipeline unless the result is held by the receiver
	assign advance     = !out_valid_q || !color_stall;
	assign pop         = advance && !status.empty;
	assign color_valid = out_valid_q;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= !status.empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Stage 1: saturation products and p
	always_comb begin
		rem_c  = DIFF_W'(HUE_SECTOR) - DIFF_W'(pop_item.rem);
		p_prod = (2*Q8_W)'(pop_item.val) * (2*Q8_W)'(Q8_W'(ONE_Q8) - pop_item.sat);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gray_s1     <= pop_item.gray;
			sector_s1   <= pop_item.sector;
			sf_prod_s1  <= PROD_W'(pop_item.sat) * PROD_W'(pop_item.rem);
			sfc_prod_s1 <= PROD_W'(pop_item.sat) * PROD_W'(rem_c);
			p_s1        <= p_prod[8 +: Q8_W];
			val_s1      <= pop_item.val;
		end
	end

	// Stage 2: divide the products by the sector width
	always_comb begin
		y_sf     = sf_prod_s1[SECTOR_SHIFT +: Y_W];
		y_sfc    = sfc_prod_s1[SECTOR_SHIFT +: Y_W];
		sf_full  = YR_W'(y_sf) * YR_W'(RECIP_15);
		sfc_full = YR_W'(y_sfc) * YR_W'(RECIP_15);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gray_s2   <= gray_s1;
			sector_s2 <= sector_s1;
			sf_s2     <= sf_full[RECIP_SHIFT +: Q8_W];
			sfc_s2    <= sfc_full[RECIP_SHIFT +: Q8_W];
			p_s2      <= p_s1;
			val_s2    <= val_s1;
		end
	end

	// Stage 3: q and t
	always_comb begin
		q_prod = (2*Q8_W)'(val_s2) * (2*Q8_W)'(Q8_W'(ONE_Q8) - sf_s2);
		t_prod = (2*Q8_W)'(val_s2) * (2*Q8_W)'(Q8_W'(ONE_Q8) - sfc_s2);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gray_s3   <= gray_s2;
			sector_s3 <= sector_s2;
			p_s3      <= p_s2;
			q_s3      <= q_prod[8 +: Q8_W];
			t_s3      <= t_prod[8 +: Q8_W];
			val_s3    <= val_s2;
		end
	end

	// Stage 4: select channels by sector, gray when saturation is zero
	always_comb begin
		if (gray_s3) begin
			r_sel = val_s3;
			g_sel = val_s3;
			b_sel = val_s3;
		end else begin
			unique case (sector_s3)
				SEC_RED_YELLOW: begin
					r_sel = val_s3; g_sel = t_s3;   b_sel = p_s3;
				end
				SEC_YELLOW_GREEN: begin
					r_sel = q_s3;   g_sel = val_s3; b_sel = p_s3;
				end
				SEC_GREEN_CYAN: begin
					r_sel = p_s3;   g_sel = val_s3; b_sel = t_s3;
				end
				SEC_CYAN_BLUE: begin
					r_sel = p_s3;   g_sel = q_s3;   b_sel = val_s3;
				end
				SEC_BLUE_MAGENTA: begin
					r_sel = t_s3;   g_sel = p_s3;   b_sel = val_s3;
				end
				default: begin
					r_sel = val_s3; g_sel = p_s3;   b_sel = q_s3;
				end
			endcase
		end
	end

	// Output register: scale and hold while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			red   <= scale_out(r_sel);
			green <= scale_out(g_sel);
			blue  <= scale_out(b_sel);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_to_rgb_placeholder_never_used.sv -----
// Clamp of one unsigned Q1.8 value to 1.0, used by the front end.
// Uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_clamp (
	input  wire  [hsvrgb_pkg::Q8_W-1:0] din,
	output logic [hsvrgb_pkg::Q8_W-1:0] dout
);
	import hsvrgb_pkg::*;

	// Clamp a Q1.8 value to 1.0
	assign dout = (din > Q8_W'(ONE_Q8)) ? Q8_W'(ONE_Q8) : din;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_converter_top.sv -----
// HSV to RGB converter, top level.
// Input channel: pixel_valid / pixel_stall with hue (1/64 degree units),
// saturation and brightness (unsigned Q1.8, 256 = 1.0). Values above 1.0
// clamp to 1.0; hue at or past 360 degrees wraps once.
// Output channel: color_valid / color_stall with red, green, blue.
// A word moves when valid is high and stall is low at a rising clock edge.
// Throughput: one pixel per clock while the receiver does not stall. A word
// enters the input stage on the accepting edge, then passes the queue, three
// arithmetic stages and the output register, whose valid bit drives
// color_valid.
// When the receiver stalls, the back end holds all its stages and the queue
// fills; the front keeps taking pixels until the queue is full, then raises
// pixel_stall. No word is lost or repeated.
// Reset (arst_n low) empties the queue and clears all valid bits at once;
// the block takes pixels on the first clock after reset is released.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_queue, hsvrgb_back, hsvrgb_clamp.
`default_nettype none

module hsv_to_rgb_converter_top #(
	parameter int QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   pixel_valid,
	output logic                                  pixel_stall,
	input  wire  [hsvrgb_pkg::HUE_W-1:0]          hue,
	input  wire  [hsvrgb_pkg::Q8_W-1:0]           saturation,
	input  wire  [hsvrgb_pkg::Q8_W-1:0]           brightness,
	output logic                                  color_valid,
	input  wire                                   color_stall,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0] red,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0] green,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0] blue
);
	import hsvrgb_pkg::*;

	queue_status_t  status;
	logic           push;
	logic           pop;
	hsv_item_t      push_item;
	hsv_item_t      pop_item;

	hsvrgb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.status      (status),
		.push        (push),
		.push_item   (push_item)
	);

	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (status)
	);

	hsvrgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.status      (status),
		.pop_item    (pop_item),
		.pop         (pop),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for hsv_to_rgb_converter_top.
// Checks each color word against a built-in HSV to RGB predictor;
// depends on hsvrgb_pkg and the converter RTL.

module tb_top;
	import hsvrgb_pkg::*;

	localparam int STALL_LIMIT = 3000;  // cycles with no word moving on either side
	localparam int TAIL_CYCLES = 24;    // settle time after the last color word
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [COMPONENT_BITS-1:0] r;
		logic [COMPONENT_BITS-1:0] g;
		logic [COMPONENT_BITS-1:0] b;
	} color_t;

	typedef enum int {RX_FREE, RX_PATTERN, RX_HEAVY} rx_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      pixel_valid;
	logic                      pixel_stall;
	logic [HUE_W-1:0]          hue;
	logic [Q8_W-1:0]           saturation;
	logic [Q8_W-1:0]           brightness;
	logic                      color_valid;
	logic                      color_stall;
	logic [COMPONENT_BITS-1:0] red;
	logic [COMPONENT_BITS-1:0] green;
	logic [COMPONENT_BITS-1:0] blue;

	color_t   expected_colors[$];
	int       err_count = 0;
	int       pixel_count = 0;
	int       color_count = 0;
	int       idle_cycles = 0;
	int       hold_request = 0;
	rx_mode_t rx_mode = RX_FREE;

	hsv_to_rgb_converter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.color_valid(color_valid),
		.color_stall(color_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predict the color word for one pixel
	function automatic color_t predict_color(input logic [HUE_W-1:0] h_in,
			input logic [Q8_W-1:0] s_in, input logic [Q8_W-1:0] v_in);
		int unsigned h, s, v, rem, sf, sfc, p, q, t, r, g, b;
		sector_t     sec;
		color_t      c;
		h = h_in % HUE_FULL;
		s = (s_in > ONE_Q8) ? ONE_Q8 : s_in;
		v = (v_in > ONE_Q8) ? ONE_Q8 : v_in;
		if (s == 0) begin
			r = v;
			g = v;
			b = v;
		end else begin
			sec = sector_t'(h / HUE_SECTOR);
			rem = h % HUE_SECTOR;
			sf  = (s * rem) / HUE_SECTOR;
			sfc = (s * (HUE_SECTOR - rem)) / HUE_SECTOR;
			p   = (v * (ONE_Q8 - s)) >> 8;
			q   = (v * (ONE_Q8 - sf)) >> 8;
			t   = (v * (ONE_Q8 - sfc)) >> 8;
			case (sec)
				SEC_RED_YELLOW: begin
					r = v; g = t; b = p;
				end
				SEC_YELLOW_GREEN: begin
					r = q; g = v; b = p;
				end
				SEC_GREEN_CYAN: begin
					r = p; g = v; b = t;
				end
				SEC_CYAN_BLUE: begin
					r = p; g = q; b = v;
				end
				SEC_BLUE_MAGENTA: begin
					r = t; g = p; b = v;
				end
				default: begin
					r = v; g = p; b = q;
				end
			endcase
		end
		c.r = COMPONENT_BITS'(((r * COMP_MAX) >> 8) & COMP_MAX);
		c.g = COMPONENT_BITS'(((g * COMP_MAX) >> 8) & COMP_MAX);
		c.b = COMPONENT_BITS'(((b * COMP_MAX) >> 8) & COMP_MAX);
		return c;
	endfunction

	// Count an error; print only the first few
	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Offer one pixel word and hold it until accepted
	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [Q8_W-1:0] s,
			input logic [Q8_W-1:0] v);
		pixel_valid <= 1'b1;
		hue         <= h;
		saturation  <= s;
		brightness  <= v;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		expected_colors.push_back(predict_color(h, s, v));
		pixel_count++;
	endtask

	// Drop valid to pause the pixel stream; an argument of zero keeps the burst going
	task automatic pause_pixels(input int n);
		if (n > 0) begin
			pixel_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Mostly in-range hue, some past 360 degrees
	function automatic logic [HUE_W-1:0] rand_hue();
		if ($urandom_range(9, 0) == 0)
			return HUE_W'($urandom_range(32767, HUE_FULL));
		return HUE_W'($urandom_range(HUE_FULL - 1, 0));
	endfunction

	// Q1.8 value with weight on zero, one and the clamped range
	function automatic logic [Q8_W-1:0] rand_q8();
		int unsigned pick;
		pick = $urandom_range(19, 0);
		if (pick < 2)
			return '0;
		if (pick < 3)
			return Q8_W'(ONE_Q8);
		if (pick < 5)
			return Q8_W'($urandom_range(511, ONE_Q8 + 1));
		return Q8_W'($urandom_range(ONE_Q8 - 1, 1));
	endfunction

	// Drive color_stall: long hold-off first, else the current pattern
	initial begin : receiver
		int  run_left;
		int  hold_left;
		logic stalled;
		run_left  = 0;
		hold_left = 0;
		stalled   = 1'b0;
		color_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				color_stall <= 1'b1;
			end else if (rx_mode == RX_FREE) begin
				color_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stalled = ~stalled;
					if (rx_mode == RX_HEAVY)
						run_left = stalled ? $urandom_range(10, 1) : $urandom_range(3, 1);
					else
						run_left = stalled ? $urandom_range(6, 1) : $urandom_range(12, 1);
				end
				run_left--;
				color_stall <= stalled;
			end
		end
	end

	// Check each accepted color word against the oldest prediction
	always @(posedge clk) begin
		color_t exp_c;
		if (arst_n && color_valid && !color_stall) begin
			color_count++;
			if (expected_colors.size() == 0) begin
				note_error($sformatf("unexpected color word r=%0d g=%0d b=%0d",
					red, green, blue));
			end else begin
				exp_c = expected_colors.pop_front();
				if (red !== exp_c.r)
					note_error($sformatf("word %0d red: expected %0d, got %0d",
						color_count, exp_c.r, red));
				if (green !== exp_c.g)
					note_error($sformatf("word %0d green: expected %0d, got %0d",
						color_count, exp_c.g, green));
				if (blue !== exp_c.b)
					note_error($sformatf("word %0d blue: expected %0d, got %0d",
						color_count, exp_c.b, blue));
			end
		end
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (color_valid && !color_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d colors outstanding",
				STALL_LIMIT, expected_colors.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Corners: hue ends and wrap, sector edges, gray, clamping, zero value
	task automatic test_corner_pixels();
		rx_mode = RX_FREE;
		send_pixel(15'd0, 9'd256, 9'd256);
		send_pixel(15'(HUE_FULL - 1), 9'd256, 9'd256);
		send_pixel(15'(HUE_FULL), 9'd256, 9'd256);
		send_pixel(15'h7FFF, 9'h1FF, 9'h1FF);
		for (int k = 1; k < SECTOR_NUM; k++) begin
			send_pixel(15'(k * HUE_SECTOR - 1), 9'd256, 9'd256);
			send_pixel(15'(k * HUE_SECTOR), 9'd256, 9'd256);
		end
		send_pixel(15'd1000, 9'd0, 9'd200);
		send_pixel(15'd5000, 9'd0, 9'h1FF);
		send_pixel(15'd12345, 9'd257, 9'd100);
		send_pixel(15'd20000, 9'd128, 9'd0);
		send_pixel(15'd1920, 9'd1, 9'd256);
		send_pixel(15'd9000, 9'd255, 9'd255);
		send_pixel(15'd0, 9'd0, 9'd0);
		send_pixel(15'h7FFF, 9'd0, 9'd0);
		pause_pixels(3);
	endtask

	// Back-to-back pixels with a free receiver
	task automatic test_full_rate(input int n_items);
		rx_mode = RX_FREE;
		repeat (n_items)
			send_pixel(rand_hue(), rand_q8(), rand_q8());
		pause_pixels(2);
	endtask

	// Hold the receiver off while pixels keep coming, so the block backs up
	task automatic test_output_holdoff(input int n_items);
		rx_mode      = RX_FREE;
		hold_request = HOLD_CYCLES;
		repeat (n_items)
			send_pixel(rand_hue(), rand_q8(), rand_q8());
		pause_pixels(2);
	endtask

	// Random pixels in bursts with gaps and a changing receiver pattern
	task automatic test_random_pixels(input int n_items);
		int sent;
		int burst;
		sent    = 0;
		rx_mode = RX_PATTERN;
		while (sent < n_items) begin
			burst = $urandom_range(20, 1);
			for (int i = 0; i < burst && sent < n_items; i++) begin
				send_pixel(rand_hue(), rand_q8(), rand_q8());
				sent++;
			end
			if ($urandom_range(3, 0) == 0)
				rx_mode = rx_mode_t'($urandom_range(2, 0));
			pause_pixels($urandom_range(6, 0));
		end
	endtask

	// Reset, run the tests, drain and report
	initial begin
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		hue         = '0;
		saturation  = '0;
		brightness  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_full_rate(40);
		test_output_holdoff(60);
		test_random_pixels(480);

		// Drain what is still in flight
		pause_pixels(1);
		rx_mode = RX_FREE;
		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d pixels and checked %0d colors: sector edges, hue wrap, clamping,",
			pixel_count, color_count);
		$display("gray, full-rate bursts, random stalls and a long output hold-off.");
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors found", err_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
